### rtl/core/complex_arith_unit_defines.svh
// Assertion macros for the complex arithmetic unit checker.
// No dependencies; included by the checker file only.
`ifndef COMPLEX_ARITH_UNIT_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define CAU_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define CAU_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define CAU_ASSERT_RST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/cau_pkg.sv
// Shared types, constants and saturation helpers for the complex arithmetic unit.
// No dependencies.
package cau_pkg;

    localparam int DATA_W = 32;
    // Remainder width of the divider: magnitude numerator shifted by up to DATA_W.
    localparam int RES_W  = 3 * DATA_W + 1;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef logic signed [DATA_W-1:0]   word_t;
    typedef logic signed [2*DATA_W-1:0] prod_t;

    localparam word_t WORD_MAX = word_t'({1'b0, {(DATA_W-1){1'b1}}});
    localparam word_t WORD_MIN = word_t'({1'b1, {(DATA_W-1){1'b0}}});

    typedef struct packed {
        op_t   req_type;
        word_t a_re;
        word_t a_im;
        word_t b_re;
        word_t b_im;
    } cau_req_t;

    typedef struct packed {
        word_t res_re;
        word_t res_im;
        logic  overflow;
        logic  div_zero;
    } cau_resp_t;

    // First front stage: sums and raw products.
    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W:0]   sum_re;
        logic signed [DATA_W:0]   sum_im;
        prod_t                    p_rr;
        prod_t                    p_ii;
        prod_t                    p_ri;
        prod_t                    p_ir;
        prod_t                    d_rr;
        prod_t                    d_ii;
    } front_t;

    // Context carried down the divider stages.
    typedef struct packed {
        logic [RES_W-1:0]    r_re;
        logic [RES_W-1:0]    r_im;
        logic [2*DATA_W-1:0] den;
        logic [DATA_W-1:0]   q_re;
        logic [DATA_W-1:0]   q_im;
        logic                big_re;
        logic                big_im;
        logic                neg_re;
        logic                neg_im;
        logic                is_div;
        logic                dz;
        cau_resp_t           direct;
    } div_ctx_t;

    typedef struct packed {
        word_t val;
        logic  ovf;
    } sat_t;

    function automatic sat_t sat_wide(input logic signed [2*DATA_W:0] v);
        sat_t            s;
        logic [DATA_W+1:0] top;
        top = v[2*DATA_W:DATA_W-1];
        if (top == '0 || top == '1) begin
            s.val = word_t'(v[DATA_W-1:0]);
            s.ovf = 1'b0;
        end else begin
            s.val = v[2*DATA_W] ? WORD_MIN : WORD_MAX;
            s.ovf = 1'b1;
        end
        return s;
    endfunction

    function automatic sat_t sat_quot(input logic [DATA_W-1:0] q, input logic neg,
                                      input logic big);
        sat_t          s;
        logic [DATA_W:0] lim;
        lim = neg ? {2'b01, {(DATA_W-1){1'b0}}} : {2'b00, {(DATA_W-1){1'b1}}};
        if (big || ({1'b0, q} > lim)) begin
            s.val = neg ? WORD_MIN : WORD_MAX;
            s.ovf = 1'b1;
        end else begin
            s.val = neg ? word_t'(~q + 1'b1) : word_t'(q);
            s.ovf = 1'b0;
        end
        return s;
    endfunction

endpackage

### rtl/core/complex_arith_unit.sv
// Complex add/sub/mul/div in signed fixed point, one beat per cycle.
// Pipeline from input accept to m_valid: 2 front stages, an oversize check and 32
// quotient-bit steps, 1 result stage, 1 output buffer; 37 registers, the first of which
// loads at the accept edge.
// Throughput: one beat per cycle; the 2-entry output buffer stalls the pipeline when full.
// Reset: synchronous active-low aresetn clears all valid bits and the buffer count.
module complex_arith_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cau_pkg::cau_req_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output cau_pkg::cau_resp_t m_data
);
    import cau_pkg::*;

    logic      en;
    logic      vld_pipe [0:DATA_W+1];
    div_ctx_t  ctx_pipe [0:DATA_W+1];
    logic      fin_valid;
    cau_resp_t fin_data;

    // Advance the whole pipeline whenever the output buffer has room.
    assign s_ready = en;

    cau_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .in_data  (s_data),
        .out_valid(vld_pipe[0]),
        .out_ctx  (ctx_pipe[0])
    );

    generate
        for (genvar k = 0; k <= DATA_W; k++) begin : g_div
            cau_div_stage #(
                .SHIFT(DATA_W - k)
            ) u_stage (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .en       (en),
                .in_valid (vld_pipe[k]),
                .in_ctx   (ctx_pipe[k]),
                .out_valid(vld_pipe[k+1]),
                .out_ctx  (ctx_pipe[k+1])
            );
        end
    endgenerate

    cau_fin_stage u_fin (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (vld_pipe[DATA_W+1]),
        .in_ctx   (ctx_pipe[DATA_W+1]),
        .out_valid(fin_valid),
        .out_data (fin_data)
    );

    cau_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (fin_valid && en),
        .push_data(fin_data),
        .room     (en),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

### rtl/core/cau_front.sv
// Front end: multiplier stage, then operand preparation for add, sub, mul and div.
// Depends on cau_pkg.
module cau_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  cau_pkg::cau_req_t in_data,
    output logic              out_valid,
    output cau_pkg::div_ctx_t out_ctx
);
    import cau_pkg::*;

    logic     s1_valid_reg;
    front_t   s1_reg, s1_next;
    logic     s2_valid_reg;
    div_ctx_t s2_reg, s2_next;

    logic signed [DATA_W:0]   a_re_x, a_im_x, b_re_x, b_im_x;
    logic signed [2*DATA_W:0] x_rr, x_ii, x_ri, x_ir;
    logic signed [2*DATA_W:0] mre, mim, nre, nim, wre, wim;
    logic [2*DATA_W:0]        mag_re, mag_im;
    logic [2*DATA_W-1:0]      den;
    sat_t                     sre, sim;

    always_comb begin
        a_re_x = (DATA_W+1)'(in_data.a_re);
        a_im_x = (DATA_W+1)'(in_data.a_im);
        b_re_x = (DATA_W+1)'(in_data.b_re);
        b_im_x = (DATA_W+1)'(in_data.b_im);
        s1_next.op = in_data.req_type;
        if (in_data.req_type == OP_SUB) begin
            s1_next.sum_re = a_re_x - b_re_x;
            s1_next.sum_im = a_im_x - b_im_x;
        end else begin
            s1_next.sum_re = a_re_x + b_re_x;
            s1_next.sum_im = a_im_x + b_im_x;
        end
        s1_next.p_rr = prod_t'(in_data.a_re) * prod_t'(in_data.b_re);
        s1_next.p_ii = prod_t'(in_data.a_im) * prod_t'(in_data.b_im);
        s1_next.p_ri = prod_t'(in_data.a_re) * prod_t'(in_data.b_im);
        s1_next.p_ir = prod_t'(in_data.a_im) * prod_t'(in_data.b_re);
        s1_next.d_rr = prod_t'(in_data.b_re) * prod_t'(in_data.b_re);
        s1_next.d_ii = prod_t'(in_data.b_im) * prod_t'(in_data.b_im);
    end

    always_comb begin
        x_rr = (2*DATA_W+1)'(s1_reg.p_rr);
        x_ii = (2*DATA_W+1)'(s1_reg.p_ii);
        x_ri = (2*DATA_W+1)'(s1_reg.p_ri);
        x_ir = (2*DATA_W+1)'(s1_reg.p_ir);
        mre  = (x_rr - x_ii) >>> FRAC_BITS;
        mim  = (x_ri + x_ir) >>> FRAC_BITS;
        nre  = x_rr + x_ii;
        nim  = x_ir - x_ri;
        den  = s1_reg.d_rr[2*DATA_W-1:0] + s1_reg.d_ii[2*DATA_W-1:0];
        mag_re = nre[2*DATA_W] ? -nre : nre;
        mag_im = nim[2*DATA_W] ? -nim : nim;
        unique case (s1_reg.op)
            OP_ADD, OP_SUB: begin
                wre = (2*DATA_W+1)'(s1_reg.sum_re);
                wim = (2*DATA_W+1)'(s1_reg.sum_im);
            end
            OP_MUL: begin
                wre = mre;
                wim = mim;
            end
            default: begin
                wre = '0;
                wim = '0;
            end
        endcase
        sre = sat_wide(wre);
        sim = sat_wide(wim);

        s2_next.r_re   = {{(RES_W-2*DATA_W-1){1'b0}}, mag_re} << FRAC_BITS;
        s2_next.r_im   = {{(RES_W-2*DATA_W-1){1'b0}}, mag_im} << FRAC_BITS;
        s2_next.den    = den;
        s2_next.q_re   = '0;
        s2_next.q_im   = '0;
        s2_next.big_re = 1'b0;
        s2_next.big_im = 1'b0;
        s2_next.neg_re = nre[2*DATA_W];
        s2_next.neg_im = nim[2*DATA_W];
        s2_next.is_div = (s1_reg.op == OP_DIV);
        s2_next.dz     = (s1_reg.op == OP_DIV) && (den == '0);
        s2_next.direct.res_re   = sre.val;
        s2_next.direct.res_im   = sim.val;
        s2_next.direct.overflow = sre.ovf | sim.ovf;
        s2_next.direct.div_zero = (s1_reg.op == OP_DIV) && (den == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_ctx   = s2_reg;

endmodule

### rtl/core/cau_div_stage.sv
// One restoring-division step for both quotient parts; top step flags oversize quotients.
// Depends on cau_pkg.
module cau_div_stage #(
    parameter int SHIFT = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  cau_pkg::div_ctx_t in_ctx,
    output logic              out_valid,
    output cau_pkg::div_ctx_t out_ctx
);
    import cau_pkg::*;

    logic             valid_reg;
    div_ctx_t         ctx_reg, ctx_next;
    logic [RES_W-1:0] dsh;
    logic             ge_re, ge_im;

    assign dsh   = {{(RES_W-2*DATA_W){1'b0}}, in_ctx.den} << SHIFT;
    assign ge_re = (in_ctx.r_re >= dsh);
    assign ge_im = (in_ctx.r_im >= dsh);

    generate
        if (SHIFT >= DATA_W) begin : g_top
            // Quotient at or above 2^DATA_W: mark it, leave the remainder.
            always_comb begin
                ctx_next        = in_ctx;
                ctx_next.big_re = ge_re;
                ctx_next.big_im = ge_im;
            end
        end else begin : g_bit
            always_comb begin
                ctx_next = in_ctx;
                if (ge_re) begin
                    ctx_next.r_re        = in_ctx.r_re - dsh;
                    ctx_next.q_re[SHIFT] = 1'b1;
                end
                if (ge_im) begin
                    ctx_next.r_im        = in_ctx.r_im - dsh;
                    ctx_next.q_im[SHIFT] = 1'b1;
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg <= ctx_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctx   = ctx_reg;

endmodule

### rtl/core/cau_fin_stage.sv
// Final stage: sign and saturate quotients, or pass the direct result.
// Depends on cau_pkg.
module cau_fin_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  cau_pkg::div_ctx_t  in_ctx,
    output logic               out_valid,
    output cau_pkg::cau_resp_t out_data
);
    import cau_pkg::*;

    logic      valid_reg;
    cau_resp_t data_reg, data_next;
    sat_t      qre, qim;

    always_comb begin
        qre = sat_quot(in_ctx.q_re, in_ctx.neg_re, in_ctx.big_re);
        qim = sat_quot(in_ctx.q_im, in_ctx.neg_im, in_ctx.big_im);
        if (in_ctx.is_div && !in_ctx.dz) begin
            data_next.res_re   = qre.val;
            data_next.res_im   = qim.val;
            data_next.overflow = qre.ovf | qim.ovf;
            data_next.div_zero = 1'b0;
        end else begin
            data_next = in_ctx.direct;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/core/cau_skid.sv
// Two-entry output buffer that decouples the pipeline from result backpressure.
// Depends on cau_pkg.
module cau_skid (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  cau_pkg::cau_resp_t push_data,
    output logic               room,
    output logic               m_valid,
    input  logic               m_ready,
    output cau_pkg::cau_resp_t m_data
);
    import cau_pkg::*;

    cau_resp_t  mem [0:1];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       pop;

    assign pop     = (count_reg != 2'd0) && m_ready;
    assign room    = (count_reg != 2'd2);
    assign m_valid = (count_reg != 2'd0);
    assign m_data  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/cau_checker.sv
// Port-level checker for complex_arith_unit, bound to the top level.
// Depends on cau_pkg and complex_arith_unit_defines.svh.
`include "complex_arith_unit_defines.svh"

module cau_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input cau_pkg::cau_req_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input cau_pkg::cau_resp_t m_data
);
    import cau_pkg::*;

    logic sat_seen;
    logic s_beat;

    assign s_beat   = s_valid && s_ready && (s_data.req_type == OP_DIV);
    assign sat_seen = (m_data.res_re == WORD_MAX) || (m_data.res_re == WORD_MIN) ||
                      (m_data.res_im == WORD_MAX) || (m_data.res_im == WORD_MIN);

    `CAU_ASSERT_NXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid, "m_valid dropped before accept")
    `CAU_ASSERT_IMP(a_dz_zero, aclk, aresetn, m_valid && m_data.div_zero, m_data.res_re == '0 && m_data.res_im == '0 && !m_data.overflow, "div_zero result not clean")
    `CAU_ASSERT_IMP(a_ovf_sat, aclk, aresetn, m_valid && m_data.overflow, sat_seen, "overflow without saturated part")
    `CAU_ASSERT_IMP(a_stall_full, aclk, aresetn, !s_ready || s_beat, m_valid || s_ready, "input stalled with empty output")
    `CAU_ASSERT_RST(a_reset_clear, aclk, !aresetn, !m_valid, "m_valid set after reset")

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data (s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

### tb/tb_complex_arith_unit.sv
// Self-checking testbench for complex_arith_unit: complex add, sub, mul, div in Q16.16.
// Depends on cau_pkg and the complex_arith_unit RTL; a class scoreboard predicts each result.
module tb_complex_arith_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import cau_pkg::*;

    class cau_scoreboard;
        cau_pkg::cau_resp_t pending[$];
        int errors = 0;
        int checked = 0;

        // Saturate a wide signed value to one word.
        function automatic cau_pkg::word_t clamp(logic signed [191:0] v, ref logic ovf);
            if (v > 192'sd2147483647) begin
                ovf = 1'b1;
                return cau_pkg::WORD_MAX;
            end
            if (v < -192'sd2147483648) begin
                ovf = 1'b1;
                return cau_pkg::WORD_MIN;
            end
            return cau_pkg::word_t'(v[31:0]);
        endfunction

        // Signed division truncating toward zero.
        function automatic logic signed [191:0] tdiv(logic signed [191:0] n,
                                                     logic signed [191:0] d);
            logic signed [191:0] nm, dm, q;
            nm = n < 0 ? -n : n;
            dm = d < 0 ? -d : d;
            q = nm / dm;
            return ((n < 0) != (d < 0)) ? -q : q;
        endfunction

        function void note_request(cau_pkg::cau_req_t r);
            logic signed [191:0] ar, ai, br, bi, re, im, den;
            cau_pkg::cau_resp_t e;
            logic ovf;
            ar = r.a_re; ai = r.a_im; br = r.b_re; bi = r.b_im;
            ovf = 1'b0;
            e.div_zero = 1'b0;
            case (r.req_type)
                cau_pkg::OP_ADD: begin
                    re = ar + br; im = ai + bi;
                end
                cau_pkg::OP_SUB: begin
                    re = ar - br; im = ai - bi;
                end
                cau_pkg::OP_MUL: begin
                    re = (ar * br - ai * bi) >>> 16;
                    im = (ar * bi + ai * br) >>> 16;
                end
                default: begin
                    den = br * br + bi * bi;
                    if (den == 0) begin
                        re = 0; im = 0; e.div_zero = 1'b1;
                    end else begin
                        re = tdiv((ar * br + ai * bi) <<< 16, den);
                        im = tdiv((ai * br - ar * bi) <<< 16, den);
                    end
                end
            endcase
            e.res_re = clamp(re, ovf);
            e.res_im = clamp(im, ovf);
            e.overflow = ovf;
            pending.push_back(e);
        endfunction

        function void check_result(cau_pkg::cau_resp_t got);
            cau_pkg::cau_resp_t e;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
                return;
            end
            e = pending.pop_front();
            if (got.res_re !== e.res_re) begin
                errors++;
                $display("%0t: res_re expected %h actual %h", $time, e.res_re, got.res_re);
            end
            if (got.res_im !== e.res_im) begin
                errors++;
                $display("%0t: res_im expected %h actual %h", $time, e.res_im, got.res_im);
            end
            if (got.overflow !== e.overflow) begin
                errors++;
                $display("%0t: overflow expected %b actual %b", $time, e.overflow,
                         got.overflow);
            end
            if (got.div_zero !== e.div_zero) begin
                errors++;
                $display("%0t: div_zero expected %b actual %b", $time, e.div_zero,
                         got.div_zero);
            end
        endfunction
    endclass

    localparam int RANDOM_BEATS = 350;
    localparam int STALL_LIMIT = 5000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    cau_req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    cau_resp_t m_data;

    cau_scoreboard sb = new();
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    int sent = 0;

    complex_arith_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Sample both handshakes at the edge, before drivers update.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_request(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", sb.pending.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: own stall pattern, plus a long hold-off on request.
    initial begin
        int phase;
        phase = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            phase++;
            if ((phase / 64) % 3 == 0) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 99) < 60);
            @(posedge aclk);
        end
    end

    function automatic word_t rand_word();
        case ($urandom_range(0, 5))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return word_t'($urandom_range(0, 8)) <<< 16;
            3: return -(word_t'($urandom_range(0, 8)) <<< 16);
            4: return word_t'($signed($urandom) >>> $urandom_range(8, 24));
            default: return word_t'($urandom);
        endcase
    endfunction

    // Offer one beat and hold it until accepted.
    task automatic send_beat(cau_req_t r);
        s_valid <= 1'b1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic send_op(op_t op, word_t ar, word_t ai, word_t br, word_t bi);
        cau_req_t r;
        r.req_type = op;
        r.a_re = ar; r.a_im = ai; r.b_re = br; r.b_im = bi;
        send_beat(r);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    initial begin
        cau_req_t r;
        int burst;
        int n;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, each operation, zero divisor, saturation.
        send_op(OP_ADD, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
        send_op(OP_ADD, 32'sh0001_0000, -32'sh0002_0000, 32'sh0003_8000, 32'sh0);
        send_op(OP_SUB, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN);
        send_op(OP_SUB, 32'sh0005_0000, 32'sh0001_0000, 32'sh0002_0000, 32'sh0004_0000);
        send_op(OP_MUL, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
        send_op(OP_MUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
        send_op(OP_MUL, WORD_MIN, 0, WORD_MIN, 0);
        send_op(OP_MUL, -32'sh1, 32'sh1, 32'sh1, 32'sh0);
        send_op(OP_MUL, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000, -32'sh0001_0000);
        send_op(OP_DIV, 32'sh0001_0000, 32'sh0001_0000, 0, 0);
        send_op(OP_DIV, WORD_MAX, WORD_MIN, 0, 0);
        send_op(OP_DIV, WORD_MAX, WORD_MAX, 32'sh1, 0);
        send_op(OP_DIV, WORD_MIN, WORD_MIN, -32'sh1, 0);
        send_op(OP_DIV, -32'sh7, 32'sh7, 32'sh0003_0000, 0);
        send_op(OP_DIV, 32'sh0006_0000, -32'sh0004_0000, 32'sh0001_0000, 32'sh0001_0000);
        send_op(OP_DIV, WORD_MIN, 32'sh1, WORD_MIN, WORD_MIN);
        send_op(OP_DIV, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN);
        send_op(OP_DIV, 32'sh0001_0000, 0, 0, 32'sh1);
        drain();

        // Long receiver hold-off while input keeps coming, so the pipeline backs up.
        hold_off = 1'b1;
        for (int i = 0; i < 80; i++) begin
            r.req_type = op_t'($urandom_range(0, 3));
            r.a_re = rand_word(); r.a_im = rand_word();
            r.b_re = rand_word(); r.b_im = rand_word();
            send_beat(r);
        end
        drain();

        n = 0;
        while (n < RANDOM_BEATS) begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst; i++) begin
                r.req_type = op_t'($urandom_range(0, 3));
                r.a_re = rand_word(); r.a_im = rand_word();
                r.b_re = rand_word(); r.b_im = rand_word();
                if (r.req_type == OP_DIV && $urandom_range(0, 19) == 0) begin
                    r.b_re = 0; r.b_im = 0;
                end
                send_beat(r);
                n++;
            end
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
        drain();
        repeat (60) @(posedge aclk);

        $display("Sent %0d beats of add, sub, mul and div, checked %0d results,",
                 sent, sb.checked);
        $display("including saturation, zero divisor and a long output stall.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
